// ----- rtl/core/ppc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the permutation parity checker.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // width of one permutation entry on the request channel
   localparam int ENTRY_W = 16;
   // entry width plus one, for range compares against the store depth
   localparam int CMP_W   = ENTRY_W + 1;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_REPEAT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_LOAD,
      ST_CHK_START,
      ST_CHK_SEEN,
      ST_CHK_TEST,
      ST_WALK_START,
      ST_WALK,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/ppc_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_req_if
// Request channel: one permutation entry per word, last word marked.
// ----------------------------------------------------------------------------
interface ppc_req_if import ppc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ENTRY_W-1:0] entry;
   logic               last_entry;

   modport source (output valid, output entry, output last_entry, input ready);
   modport sink   (input valid, input entry, input last_entry, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ppc_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_rsp_if
// Response channel: parity and status of one closed permutation.
// ----------------------------------------------------------------------------
interface ppc_rsp_if import ppc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                odd_parity;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output odd_parity, output status, input ready);
   modport sink   (input valid, input odd_parity, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ppc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/permutation_parity_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// permutation_parity_checker
// Stores a permutation one entry per word, checks range and repeats through
// a seen map, then walks the cycles to give the parity or an error status.
// ----------------------------------------------------------------------------
// Load: one entry per cycle. After the closing entry, the check reads the
// store, then reads and updates the seen map for each entry (one RAM port
// each); then the cycle walk runs, or on an error a cleanup clears the seen
// map below the count, before the response is registered.
// One permutation at a time: the request side stalls from the closing entry
// until the response is registered.
// Reset: synchronous; a sweep over all MAX_LENGTH positions clears the seen
// map, with req ready low for its length.
// ----------------------------------------------------------------------------
module permutation_parity_checker import ppc_pkg::*; #(
   parameter int MAX_LENGTH = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   ppc_req_if.sink    req_if,
   ppc_rsp_if.source  rsp_if
);

   localparam int IDX_W = $clog2(MAX_LENGTH);
   localparam int CNT_W = $clog2(MAX_LENGTH + 1);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               cycles_ff, cycles_in;
   logic               in_cycle_ff, in_cycle_in;
   logic               fwd_ff, fwd_in;
   status_type         err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_parity_ff, rsp_parity_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               store_we, store_re;
   logic [IDX_W-1:0]   store_wa, store_ra;
   logic [IDX_W:0]     store_wd, store_rd;
   logic               seen_we, seen_re;
   logic [IDX_W-1:0]   seen_wa, seen_ra;
   logic               seen_wd, seen_rd;

   logic               accept;
   logic               close;
   logic               last_idx;
   logic [IDX_W-1:0]   idx_next;
   logic [IDX_W-1:0]   store_idx;
   logic               out_of_range;
   logic               unvisited;
   logic               rsp_free;

   ppc_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_LENGTH)) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_wa),
      .wr_data (store_wd),
      .rd_en   (store_re),
      .rd_addr (store_ra),
      .rd_data (store_rd)
   );

   // set in the check pass, cleared again as the walk visits each position or by the error cleanup
   ppc_ram #(.WIDTH(1), .DEPTH(MAX_LENGTH)) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_we),
      .wr_addr (seen_wa),
      .wr_data (seen_wd),
      .rd_en   (seen_re),
      .rd_addr (seen_ra),
      .rd_data (seen_rd)
   );

   assign accept    = req_if.valid && req_if.ready;
   assign close     = req_if.last_entry || (count_ff == IDX_W'(MAX_LENGTH - 1));
   assign last_idx  = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);
   assign idx_next  = idx_ff + IDX_W'(1);
   assign store_idx = store_rd[IDX_W-1:0];
   // top bit of a stored word flags an entry beyond the store depth
   assign out_of_range = store_rd[IDX_W] || (CNT_W'(store_idx) >= n_ff);
   // a clear written in the cycle of the read is not seen by that read
   assign unvisited = seen_rd && !fwd_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready      = (state_ff == ST_LOAD);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.odd_parity = rsp_parity_ff;
   assign rsp_if.status     = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (idx_ff == IDX_W'(MAX_LENGTH - 1)) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (accept && close) state_in = ST_CHK_START;
         end
         ST_CHK_START: begin
            state_in = ST_CHK_SEEN;
         end
         ST_CHK_SEEN: begin
            state_in = out_of_range ? ST_CLEAR : ST_CHK_TEST;
         end
         ST_CHK_TEST: begin
            priority if (seen_rd) state_in = ST_CLEAR;
            else if (last_idx)   state_in = ST_WALK_START;
            else                 state_in = ST_CHK_SEEN;
         end
         ST_WALK_START: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!unvisited && last_idx) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (last_idx) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      cycles_in     = cycles_ff;
      in_cycle_in   = in_cycle_ff;
      fwd_in        = fwd_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_parity_in = rsp_parity_ff;
      rsp_status_in = rsp_status_ff;

      store_we = 1'b0;
      store_wa = count_ff;
      store_wd = {({1'b0, req_if.entry} >= CMP_W'(MAX_LENGTH)), req_if.entry[IDX_W-1:0]};
      store_re = 1'b0;
      store_ra = idx_ff;
      seen_we  = 1'b0;
      seen_wa  = idx_ff;
      seen_wd  = 1'b0;
      seen_re  = 1'b0;
      seen_ra  = store_idx;

      unique case (state_ff)
         ST_INIT: begin
            seen_we = 1'b1;
            idx_in  = (idx_ff == IDX_W'(MAX_LENGTH - 1)) ? '0 : idx_next;
         end
         ST_LOAD: begin
            if (accept) begin
               store_we = 1'b1;
               if (close) begin
                  count_in = '0;
                  n_in     = CNT_W'(count_ff) + CNT_W'(1);
                  idx_in   = '0;
                  err_in   = STATUS_OK;
               end else begin
                  count_in = count_ff + IDX_W'(1);
               end
            end
         end
         ST_CHK_START: begin
            store_re = 1'b1;
         end
         ST_CHK_SEEN: begin
            if (out_of_range) begin
               err_in = STATUS_RANGE;
               idx_in = '0;
            end else begin
               seen_re = 1'b1;
            end
         end
         ST_CHK_TEST: begin
            if (seen_rd) begin
               err_in = STATUS_REPEAT;
               idx_in = '0;
            end else begin
               seen_we = 1'b1;
               seen_wa = store_idx;
               seen_wd = 1'b1;
               if (last_idx) begin
                  idx_in = '0;
               end else begin
                  idx_in   = idx_next;
                  store_re = 1'b1;
                  store_ra = idx_next;
               end
            end
         end
         ST_WALK_START: begin
            seen_re     = 1'b1;
            seen_ra     = idx_ff;
            store_re    = 1'b1;
            addr_in     = idx_ff;
            fwd_in      = 1'b0;
            cycles_in   = 1'b0;
            in_cycle_in = 1'b0;
         end
         ST_WALK: begin
            if (unvisited) begin
               // mark visited and follow the entry to the next position
               seen_we     = 1'b1;
               seen_wa     = addr_ff;
               seen_re     = 1'b1;
               seen_ra     = store_idx;
               store_re    = 1'b1;
               store_ra    = store_idx;
               addr_in     = store_idx;
               fwd_in      = (store_idx == addr_ff);
               in_cycle_in = 1'b1;
               if (!in_cycle_ff) cycles_in = !cycles_ff;
            end else begin
               in_cycle_in = 1'b0;
               fwd_in      = 1'b0;
               if (!last_idx) begin
                  idx_in   = idx_next;
                  addr_in  = idx_next;
                  seen_re  = 1'b1;
                  seen_ra  = idx_next;
                  store_re = 1'b1;
                  store_ra = idx_next;
               end
            end
         end
         ST_CLEAR: begin
            // only positions below the count can have been marked
            seen_we = 1'b1;
            idx_in  = last_idx ? '0 : idx_next;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_ff;
               // parity is n minus the number of cycles, modulo two
               rsp_parity_in = (err_ff == STATUS_OK) ? (cycles_ff ^ n_ff[0]) : 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= '0;
         idx_ff       <= '0;
         cycles_ff    <= 1'b0;
         in_cycle_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         cycles_ff    <= cycles_in;
         in_cycle_ff  <= in_cycle_in;
         fwd_ff       <= fwd_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      addr_ff       <= addr_in;
      rsp_parity_ff <= rsp_parity_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
`default_nettype wire
